/* rtl/core/qclt_pkg.sv */
// Package for the quoted command line tokenizer.
// Holds sizes, character codes, the scan mode type and the result record.
// No dependencies; every other file imports it.
package qclt_pkg;

  // Line and argument sizing
  localparam int LINE_LEN  = 1024;
  localparam int ARG_SLOTS = 64;
  localparam int POS_W     = 10;
  localparam int TOK_W     = 6;
  localparam int CHAR_W    = 8;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  // First position at which a byte no longer counts, and token cap
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LEN - 1);
  localparam logic [TOK_W-1:0] TOK_CAP  = TOK_W'(ARG_SLOTS - 1);
  localparam logic [TOK_W-1:0] MAX_TOKENS_RST = 6'd63;

  // Register index
  localparam logic REG_MAX_TOKENS = 1'b0;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  // Scan mode
  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_QUOTED  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_STOPPED = 3'd4
  } qclt_mode_t;

  // One result request
  typedef struct packed {
    logic             token_valid;
    logic [POS_W-1:0] token_start;
    logic [POS_W-1:0] token_length;
    logic [TOK_W-1:0] token_index;
    logic             line_done;
    logic [TOK_W-1:0] token_count;
  } qclt_result_t;

endpackage

/* rtl/core/qclt_if.sv */
// Stream interfaces for the tokenizer: byte input and token result output.
// Depends on qclt_pkg for field widths.
interface qclt_in_if import qclt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface qclt_out_if import qclt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             token_valid;
  logic [POS_W-1:0] token_start;
  logic [POS_W-1:0] token_length;
  logic [TOK_W-1:0] token_index;
  logic             line_done;
  logic [TOK_W-1:0] token_count;

  modport source (output valid, output token_valid, output token_start,
                  output token_length, output token_index, output line_done,
                  output token_count, input ready);
  modport sink   (input valid, input token_valid, input token_start,
                  input token_length, input token_index, input line_done,
                  input token_count, output ready);
endinterface

/* rtl/core/qclt_cfg.sv */
// APB-style configuration register block: holds max_tokens.
// Depends on qclt_pkg.
module qclt_cfg
  import qclt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [TOK_W-1:0]  max_tokens
);

  logic [TOK_W-1:0] max_tokens_r;
  logic [TOK_W-1:0] max_tokens_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_TOKENS);

  // Register write
  always_comb begin
    max_tokens_nxt = max_tokens_r;
    if (wr_en) begin
      max_tokens_nxt = pwdata[TOK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r <= MAX_TOKENS_RST;
    end else begin
      max_tokens_r <= max_tokens_nxt;
    end
  end

  // Read back; other addresses read as zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_TOKENS) begin
      prdata = {{(CFG_DW-TOK_W){1'b0}}, max_tokens_r};
    end
  end

  assign max_tokens = max_tokens_r;

endmodule

/* rtl/core/qclt_in_stage.sv */
// Input register: captures one byte request and holds it until the scanner
// takes it. Depends on qclt_pkg.
module qclt_in_stage
  import qclt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char,
  output logic              in_ready,
  input  logic              advance,
  output logic              a_valid,
  output logic [CHAR_W-1:0] a_char
);

  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              fire;

  // Free when empty or when the held byte moves on this cycle
  assign in_ready = !valid_r || advance;
  assign fire     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    char_nxt  = char_r;
    if (fire) begin
      valid_nxt = 1'b1;
      char_nxt  = in_char;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign a_valid = valid_r;
  assign a_char  = char_r;

endmodule

/* rtl/core/qclt_scan.sv */
// Scanner: line state registers and the per-byte transition and result logic.
// Depends on qclt_pkg.
module qclt_scan
  import qclt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] c,
  input  logic [TOK_W-1:0]  max_tokens,
  output logic              has_res,
  output qclt_result_t      res
);

  qclt_mode_t       mode_r, mode_nxt;
  logic             qsingle_r, qsingle_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [TOK_W-1:0] tokens_r, tokens_nxt;

  logic             is_nul, is_sp, is_quote, is_close, in_token, past_end;
  logic             at_limit, emit_mid;
  logic [TOK_W-1:0] limit;

  // Byte decode
  assign is_nul   = (c == CH_NUL);
  assign is_sp    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  assign is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
  assign is_close = qsingle_r ? (c == CH_SQUOTE) : (c == CH_DQUOTE);
  assign in_token = (mode_r == MODE_PLAIN) || (mode_r == MODE_QUOTED) ||
                    (mode_r == MODE_ESCAPE);
  assign past_end = (pos_r >= POS_LAST);
  assign limit    = (max_tokens > TOK_CAP) ? TOK_CAP : max_tokens;
  assign at_limit = (tokens_r >= limit);

  // A token ends on a separator, a hash or the matching quote
  always_comb begin
    emit_mid = 1'b0;
    case (mode_r)
      MODE_PLAIN:  emit_mid = is_sp || (c == CH_HASH);
      MODE_QUOTED: emit_mid = is_close;
      default:     emit_mid = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    mode_nxt    = mode_r;
    qsingle_nxt = qsingle_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    tokens_nxt  = tokens_r;
    if (is_nul) begin
      mode_nxt    = MODE_BETWEEN;
      qsingle_nxt = 1'b0;
      pos_nxt     = '0;
      start_nxt   = '0;
      tokens_nxt  = '0;
    end else if (!past_end) begin
      pos_nxt = pos_r + 1'b1;
      case (mode_r)
        MODE_BETWEEN: begin
          if (is_sp) begin
            mode_nxt = MODE_BETWEEN;
          end else if ((c == CH_HASH) || at_limit) begin
            mode_nxt = MODE_STOPPED;
          end else if (is_quote) begin
            mode_nxt    = MODE_QUOTED;
            qsingle_nxt = (c == CH_SQUOTE);
            start_nxt   = pos_r + 1'b1;
          end else begin
            mode_nxt  = MODE_PLAIN;
            start_nxt = pos_r;
          end
        end
        MODE_PLAIN: begin
          if (is_sp) begin
            mode_nxt = MODE_BETWEEN;
          end else if (c == CH_HASH) begin
            mode_nxt = MODE_STOPPED;
          end
        end
        MODE_QUOTED: begin
          if (is_close) begin
            mode_nxt = MODE_BETWEEN;
          end else if (c == CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end
        end
        MODE_ESCAPE: mode_nxt = MODE_QUOTED;
        default:     mode_nxt = MODE_STOPPED;
      endcase
      if (emit_mid) begin
        tokens_nxt = tokens_r + 1'b1;
      end
    end
  end

  // Result for this byte
  always_comb begin
    res     = '0;
    has_res = 1'b0;
    if (is_nul) begin
      has_res       = 1'b1;
      res.line_done = 1'b1;
      res.token_count = tokens_r;
      if (in_token) begin
        res.token_valid  = 1'b1;
        res.token_start  = start_r;
        res.token_length = pos_r - start_r;
        res.token_index  = tokens_r;
        res.token_count  = tokens_r + 1'b1;
      end
    end else if (!past_end && emit_mid) begin
      has_res          = 1'b1;
      res.token_valid  = 1'b1;
      res.token_start  = start_r;
      res.token_length = pos_r - start_r;
      res.token_index  = tokens_r;
    end
  end

  // State registers, updated only when the byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BETWEEN;
      qsingle_r <= 1'b0;
      pos_r     <= '0;
      start_r   <= '0;
      tokens_r  <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      tokens_r  <= tokens_nxt;
    end
  end

endmodule

/* rtl/core/qclt_out_stage.sv */
// Output register: holds one result request until the sink takes it.
// Depends on qclt_pkg.
module qclt_out_stage
  import qclt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  qclt_result_t res_in,
  output logic         slot_free,
  output logic         out_valid,
  input  logic         out_ready,
  output qclt_result_t res_out
);

  logic         valid_r, valid_nxt;
  qclt_result_t res_r, res_nxt;

  // Slot can take a new request when empty or being drained now
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res_in;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

/* rtl/core/quoted_command_line_tokenizer_core.sv */
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      char_in[7:0]
// out_ch    out  valid/ready      token_valid, token_start, token_length,
//                                 token_index, line_done, token_count
// cfg       in   APB write/read   max_tokens at byte address 0
//
// One byte per cycle sustained while results are taken; a result reaches the output
// register from the input register through the combinational scan step. Synchronous
// active-low reset clears all line state and sets max_tokens to 63. While a result
// waits at the output, bytes that produce no result still flow; a byte that would
// produce one waits.
// Top level of the tokenizer. Depends on qclt_pkg, qclt_if and the qclt_* modules.
module quoted_command_line_tokenizer_core
  import qclt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  qclt_in_if.sink           in_ch,
  qclt_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic              in_ready;
  logic              a_valid;
  logic [CHAR_W-1:0] a_char;
  logic              advance;
  logic              has_res;
  logic              slot_free;
  logic              out_valid;
  logic [TOK_W-1:0]  max_tokens;
  qclt_result_t      scan_res;
  qclt_result_t      out_res;

  // Configuration
  qclt_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_tokens (max_tokens)
  );

  // Input register
  qclt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_char  (in_ch.char_in),
    .in_ready (in_ready),
    .advance  (advance),
    .a_valid  (a_valid),
    .a_char   (a_char)
  );
  assign in_ch.ready = in_ready;

  // Held byte moves on unless its result has nowhere to go
  assign advance = a_valid && (!has_res || slot_free);

  // Scanner
  qclt_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .c          (a_char),
    .max_tokens (max_tokens),
    .has_res    (has_res),
    .res        (scan_res)
  );

  // Output register
  qclt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_res),
    .res_in    (scan_res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res_out   (out_res)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.token_valid  = out_res.token_valid;
  assign out_ch.token_start  = out_res.token_start;
  assign out_ch.token_length = out_res.token_length;
  assign out_ch.token_index  = out_res.token_index;
  assign out_ch.line_done    = out_res.line_done;
  assign out_ch.token_count  = out_res.token_count;

endmodule
